@@ src/bal_pkg.sv @@
package bal_pkg;

    localparam int unsigned COUNT_W = 9;
    localparam int unsigned WORD_W  = 32;
    localparam int unsigned INDEX_W = 8;

    typedef enum logic [1:0] {
        REQ_APPEND = 2'd0,
        REQ_GET    = 2'd1,
        REQ_SET    = 2'd2,
        REQ_REMOVE = 2'd3
    } req_kind_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_RANGE = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SHIFT,
        ST_FINISH
    } state_t;

endpackage

@@ src/bal_store.sv @@
module bal_store #(
    parameter int unsigned DEPTH = 256
) (
    input  logic                                clk,
    input  logic                                wr_en,
    input  logic [$clog2(DEPTH)-1:0]            wr_addr,
    input  logic [bal_pkg::WORD_W-1:0]          wr_data,
    input  logic [$clog2(DEPTH)-1:0]            rd_addr,
    output logic [bal_pkg::WORD_W-1:0]          rd_data
);
    import bal_pkg::*;

    logic [WORD_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

@@ src/bounded_array_list.sv @@
// request path: append and set pass IDLE and FINISH, get passes IDLE, READ and FINISH,
// remove passes SHIFT once per entry above index, then FINISH, one memory read and
// write per shift step; one request in flight at a time, req_stall high outside IDLE;
// a finished response may wait in the output register while the next request is taken
// reset: count zero, capacity_limit 256; store contents undefined until written
module bounded_array_list #(
    parameter int unsigned DEPTH = 256
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            capacity_limit_we,
    input  logic [bal_pkg::COUNT_W-1:0]     capacity_limit,
    input  logic                            req_valid,
    output logic                            req_stall,
    input  bal_pkg::req_kind_t              req_type,
    input  logic [bal_pkg::INDEX_W-1:0]     index,
    input  logic [bal_pkg::WORD_W-1:0]      value,
    output logic                            rsp_valid,
    input  logic                            rsp_stall,
    output logic [bal_pkg::WORD_W-1:0]      read_value,
    output logic [bal_pkg::COUNT_W-1:0]     count,
    output bal_pkg::status_t                status
);
    import bal_pkg::*;

    localparam int unsigned AW = $clog2(DEPTH);

    state_t             state_reg, state_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [COUNT_W-1:0] cap_reg;
    logic [COUNT_W-1:0] ptr_reg, ptr_next;
    logic [WORD_W-1:0]  res_value_reg, res_value_next;
    status_t            res_status_reg, res_status_next;
    logic               out_valid_reg, out_valid_next;
    logic [WORD_W-1:0]  out_value_reg, out_value_next;
    logic [COUNT_W-1:0] out_count_reg, out_count_next;
    status_t            out_status_reg, out_status_next;

    logic [COUNT_W-1:0] lim;
    logic [COUNT_W-1:0] idx_ext;
    logic [COUNT_W-1:0] idx_plus1;
    logic [COUNT_W-1:0] ptr_plus1;
    logic [COUNT_W-1:0] ptr_plus2;
    logic               mem_we;
    logic [AW-1:0]      mem_wa;
    logic [WORD_W-1:0]  mem_wd;
    logic [AW-1:0]      mem_ra;
    logic [WORD_W-1:0]  mem_rd;

    bal_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_wa),
        .wr_data (mem_wd),
        .rd_addr (mem_ra),
        .rd_data (mem_rd)
    );

    // limit in effect: min(capacity_limit, DEPTH)
    assign lim       = (32'(cap_reg) < 32'(DEPTH)) ? cap_reg : COUNT_W'(DEPTH);
    assign idx_ext   = COUNT_W'(index);
    assign idx_plus1 = idx_ext + COUNT_W'(1);
    assign ptr_plus1 = ptr_reg + COUNT_W'(1);
    assign ptr_plus2 = ptr_reg + COUNT_W'(2);

    assign req_stall  = (state_reg != ST_IDLE);
    assign rsp_valid  = out_valid_reg;
    assign read_value = out_value_reg;
    assign count      = out_count_reg;
    assign status     = out_status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            cap_reg       <= COUNT_W'(256);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (capacity_limit_we)
            begin
                cap_reg <= capacity_limit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg        <= ptr_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        out_value_reg  <= out_value_next;
        out_count_reg  <= out_count_next;
        out_status_reg <= out_status_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        ptr_next        = ptr_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && rsp_stall;
        out_value_next  = out_value_reg;
        out_count_next  = out_count_reg;
        out_status_next = out_status_reg;
        mem_we          = 1'b0;
        mem_wa          = AW'(count_reg);
        mem_wd          = value;
        mem_ra          = AW'(index);

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    res_value_next  = '0;
                    res_status_next = STAT_OK;
                    state_next      = ST_FINISH;
                    case (req_type)
                        REQ_APPEND:
                        begin
                            if (count_reg >= lim)
                            begin
                                res_status_next = STAT_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                mem_wa     = AW'(count_reg);
                                count_next = count_reg + COUNT_W'(1);
                            end
                        end
                        REQ_GET:
                        begin
                            if (idx_ext >= count_reg)
                            begin
                                res_status_next = STAT_RANGE;
                            end
                            else
                            begin
                                mem_ra     = AW'(index);
                                state_next = ST_READ;
                            end
                        end
                        REQ_SET:
                        begin
                            if (idx_ext >= lim)
                            begin
                                res_status_next = STAT_RANGE;
                            end
                            else
                            begin
                                mem_we = 1'b1;
                                mem_wa = AW'(index);
                            end
                        end
                        REQ_REMOVE:
                        begin
                            if (idx_ext >= count_reg)
                            begin
                                res_status_next = STAT_RANGE;
                            end
                            else
                            begin
                                count_next = count_reg - COUNT_W'(1);
                                ptr_next   = idx_ext;
                                mem_ra     = AW'(idx_plus1);
                                if (idx_plus1 < count_reg)
                                begin
                                    state_next = ST_SHIFT;
                                end
                            end
                        end
                        default:
                        begin
                            res_status_next = STAT_RANGE;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                res_value_next = mem_rd;
                state_next     = ST_FINISH;
            end
            ST_SHIFT:
            begin
                // move entry ptr+1 down to ptr, fetch the next one
                mem_we = 1'b1;
                mem_wa = AW'(ptr_reg);
                mem_wd = mem_rd;
                mem_ra = AW'(ptr_plus2);
                if (ptr_plus1 < count_reg)
                begin
                    ptr_next = ptr_plus1;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || !rsp_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = res_value_reg;
                    out_count_next  = count_reg;
                    out_status_next = res_status_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= 32'(DEPTH))
        else $error("count above depth");

    a_count_only_on_request: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(count_reg) |-> $past(req_valid && !req_stall))
        else $error("count changed without a request");

    a_shift_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SHIFT) |-> (ptr_reg < count_reg))
        else $error("shift pointer beyond count");

    a_error_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_status_reg != STAT_OK)) |-> (out_value_reg == '0))
        else $error("failed request returned data");

endmodule

@@ test/list_checker.sv @@
module list_checker #(
    parameter int unsigned DEPTH = 256
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            capacity_limit_we,
    input  logic [bal_pkg::COUNT_W-1:0]     capacity_limit,
    input  logic                            req_valid,
    input  logic                            req_stall,
    input  bal_pkg::req_kind_t              req_type,
    input  logic [bal_pkg::INDEX_W-1:0]     index,
    input  logic [bal_pkg::WORD_W-1:0]      value,
    input  logic                            rsp_valid,
    input  logic                            rsp_stall,
    input  logic [bal_pkg::WORD_W-1:0]      read_value,
    input  logic [bal_pkg::COUNT_W-1:0]     count,
    input  bal_pkg::status_t                status,
    output int                              mismatch_count,
    output int                              awaited,
    output logic [bal_pkg::COUNT_W-1:0]     tracked_count
);
    import bal_pkg::*;

    typedef struct packed {
        logic [WORD_W-1:0]  rd;
        logic [COUNT_W-1:0] cnt;
        status_t            st;
    } list_rsp_t;

    logic [WORD_W-1:0]  words [DEPTH];
    int unsigned        entries;
    logic [COUNT_W-1:0] cap_reg;
    list_rsp_t          awaited_rsps [$];
    int                 errs;

    function automatic list_rsp_t apply_list_request(input req_kind_t kind,
                                                     input logic [INDEX_W-1:0] idx,
                                                     input logic [WORD_W-1:0] word);
        list_rsp_t   r;
        int unsigned lim;
        lim = (cap_reg < DEPTH) ? cap_reg : DEPTH;
        r.rd = '0;
        r.st = STAT_OK;
        case (kind)
            REQ_APPEND:
            begin
                if (entries >= lim)
                    r.st = STAT_FULL;
                else
                begin
                    words[entries] = word;
                    entries++;
                end
            end
            REQ_GET:
            begin
                if (idx >= entries)
                    r.st = STAT_RANGE;
                else
                    r.rd = words[idx];
            end
            REQ_SET:
            begin
                if (idx >= lim)
                    r.st = STAT_RANGE;
                else
                    words[idx] = word;
            end
            default:
            begin
                if (idx >= entries)
                    r.st = STAT_RANGE;
                else
                begin
                    for (int unsigned i = idx; i + 1 < entries; i++)
                        words[i] = words[i + 1];
                    entries--;
                end
            end
        endcase
        r.cnt = entries[COUNT_W-1:0];
        return r;
    endfunction

    task automatic note_mismatch(input list_rsp_t want, input list_rsp_t got);
        if (errs < 10)
            $display("%0t rsp mismatch: expected rd=%h cnt=%0d st=%0d, got rd=%h cnt=%0d st=%0d",
                     $time, want.rd, want.cnt, want.st, got.rd, got.cnt, got.st);
        errs++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        list_rsp_t want;
        list_rsp_t got;
        if (!rst_n)
        begin
            awaited_rsps.delete();
            entries = 0;
            cap_reg = 9'd256;
            errs = 0;
            mismatch_count <= 0;
            awaited <= 0;
            tracked_count <= '0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                got.rd = read_value;
                got.cnt = count;
                got.st = status;
                if (awaited_rsps.size() == 0)
                begin
                    if (errs < 10)
                        $display("%0t unexpected rsp: rd=%h cnt=%0d st=%0d",
                                 $time, read_value, count, status);
                    errs++;
                end
                else
                begin
                    want = awaited_rsps.pop_front();
                    if (got.rd !== want.rd || got.cnt !== want.cnt || got.st !== want.st)
                        note_mismatch(want, got);
                end
            end
            if (capacity_limit_we)
                cap_reg = capacity_limit;
            if (req_valid && !req_stall)
                awaited_rsps.push_back(apply_list_request(req_type, index, value));
            awaited <= awaited_rsps.size();
            tracked_count <= entries[COUNT_W-1:0];
            mismatch_count <= errs;
        end
    end

endmodule

@@ test/tb_top.sv @@
module tb_top;
    import bal_pkg::*;

    localparam int unsigned DEPTH = 256;

    logic               clk;
    logic               rst_n;
    logic               capacity_limit_we;
    logic [COUNT_W-1:0] capacity_limit;
    logic               req_valid;
    logic               req_stall;
    req_kind_t          req_type;
    logic [INDEX_W-1:0] index;
    logic [WORD_W-1:0]  value;
    logic               rsp_valid;
    logic               rsp_stall;
    logic [WORD_W-1:0]  read_value;
    logic [COUNT_W-1:0] count;
    status_t            status;

    int                 mismatch_count;
    int                 awaited;
    logic [COUNT_W-1:0] tracked_count;

    int burst_left = 4;
    int limit_now = 256;
    int stall_mode;
    int stall_tick;

    bounded_array_list #(.DEPTH(DEPTH)) u_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .capacity_limit_we (capacity_limit_we),
        .capacity_limit    (capacity_limit),
        .req_valid         (req_valid),
        .req_stall         (req_stall),
        .req_type          (req_type),
        .index             (index),
        .value             (value),
        .rsp_valid         (rsp_valid),
        .rsp_stall         (rsp_stall),
        .read_value        (read_value),
        .count             (count),
        .status            (status)
    );

    list_checker #(.DEPTH(DEPTH)) u_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .capacity_limit_we (capacity_limit_we),
        .capacity_limit    (capacity_limit),
        .req_valid         (req_valid),
        .req_stall         (req_stall),
        .req_type          (req_type),
        .index             (index),
        .value             (value),
        .rsp_valid         (rsp_valid),
        .rsp_stall         (rsp_stall),
        .read_value        (read_value),
        .count             (count),
        .status            (status),
        .mismatch_count    (mismatch_count),
        .awaited           (awaited),
        .tracked_count     (tracked_count)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // receiver stall pattern; stall_tick sets when a random mode is picked anew
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            stall_mode <= 0;
            stall_tick <= 0;
        end
        else
        begin
            stall_tick <= stall_tick + 1;
            if (stall_tick % 100 == 99)
                stall_mode <= $urandom_range(0, 3);
            case (stall_mode)
                0: rsp_stall <= 1'b0;
                1: rsp_stall <= ($urandom_range(0, 3) == 0);
                2: rsp_stall <= ($urandom_range(0, 9) < 7);
                default: rsp_stall <= ((stall_tick % 16) < 9);
            endcase
        end
    end

    task automatic send_req(input req_kind_t kind, input logic [INDEX_W-1:0] idx,
                            input logic [WORD_W-1:0] word);
        int gap;
        req_valid <= 1'b1;
        req_type <= kind;
        index <= idx;
        value <= word;
        do
            @(posedge clk);
        while (req_stall);
        burst_left--;
        if (burst_left <= 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 4);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 12);
        end
    endtask

    task automatic settle();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (awaited != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_limit(input int lim);
        settle();
        capacity_limit_we <= 1'b1;
        capacity_limit <= lim[COUNT_W-1:0];
        limit_now = lim;
        @(posedge clk);
        capacity_limit_we <= 1'b0;
    endtask

    function automatic logic [INDEX_W-1:0] pick_index(input int bound);
        if (bound > 0 && $urandom_range(0, 4) != 0)
            return INDEX_W'($urandom_range(0, bound - 1));
        return INDEX_W'($urandom_range(0, 255));
    endfunction

    task automatic random_items(input int n, input int append_weight);
        int        pick;
        int        set_span;
        req_kind_t kind;
        for (int k = 0; k < n; k++)
        begin
            pick = $urandom_range(0, append_weight + 69);
            if (pick < append_weight)
                kind = REQ_APPEND;
            else if (pick < append_weight + 25)
                kind = REQ_GET;
            else if (pick < append_weight + 45)
                kind = REQ_SET;
            else
                kind = REQ_REMOVE;
            set_span = (limit_now < 256) ? limit_now : 256;
            send_req(kind, pick_index((kind == REQ_SET) ? set_span : int'(tracked_count)),
                     $urandom());
        end
    endtask

    task automatic fill_list();
        while (tracked_count < 256)
            send_req(REQ_APPEND, '0, $urandom());
        repeat (2) send_req(REQ_APPEND, '0, $urandom());
    endtask

    initial
    begin
        rst_n <= 1'b0;
        capacity_limit_we <= 1'b0;
        capacity_limit <= '0;
        req_valid <= 1'b0;
        req_type <= REQ_APPEND;
        index <= '0;
        value <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // empty list, extremes of index and value
        send_req(REQ_GET, 8'd0, '0);
        send_req(REQ_REMOVE, 8'd0, '0);
        send_req(REQ_SET, 8'd255, 32'hFFFF_FFFF);
        send_req(REQ_SET, 8'd0, 32'h0000_0000);
        send_req(REQ_APPEND, 8'd0, 32'hFFFF_FFFF);
        send_req(REQ_APPEND, 8'd255, 32'h0000_0000);
        send_req(REQ_APPEND, 8'd0, 32'hA5A5_A5A5);
        send_req(REQ_APPEND, 8'd0, 32'h5A5A_5A5A);
        send_req(REQ_GET, 8'd3, '0);
        send_req(REQ_GET, 8'd4, '0);
        send_req(REQ_REMOVE, 8'd1, '0);
        send_req(REQ_GET, 8'd1, '0);
        send_req(REQ_REMOVE, 8'd2, '0);
        send_req(REQ_REMOVE, 8'd255, '0);
        send_req(REQ_SET, 8'd1, 32'h8000_0000);
        send_req(REQ_GET, 8'd1, '0);

        // zero capacity, limit below count
        write_limit(0);
        send_req(REQ_APPEND, 8'd0, 32'h1234_5678);
        send_req(REQ_SET, 8'd0, 32'h1234_5678);
        send_req(REQ_GET, 8'd0, '0);
        send_req(REQ_REMOVE, 8'd0, '0);

        write_limit(1);
        send_req(REQ_APPEND, 8'd0, 32'hCAFE_F00D);
        send_req(REQ_SET, 8'd1, 32'h7F80_0000);
        send_req(REQ_SET, 8'd0, 32'h7F80_0000);
        send_req(REQ_GET, 8'd0, '0);
        send_req(REQ_REMOVE, 8'd0, '0);
        send_req(REQ_APPEND, 8'd0, 32'hFF80_0000);

        random_items(20, 25);
        write_limit(2);
        random_items(20, 25);
        write_limit($urandom_range(3, 20));
        random_items(30, 35);
        write_limit(0);
        random_items(15, 25);
        write_limit(511);
        random_items(30, 40);
        write_limit(256);
        fill_list();
        random_items(15, 25);
        write_limit(7);
        random_items(20, 20);

        req_valid <= 1'b0;
        for (int n = 0; n < 20000 && awaited != 0; n++)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (mismatch_count == 0 && awaited == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
